FILE: hw/rtl/lemq_pkg.sv
// package for the line envelope max query block
// shared widths, function and status codes, multiplier operand types
// no dependencies
`timescale 1ns / 1ps

package lemq_pkg;

  localparam int DEFAULT_HULL_DEPTH = 1024;

  localparam int FUNC_W   = 2;
  localparam int SLOPE_W  = 20;
  localparam int OFFSET_W = 48;
  localparam int X_W      = 32;
  localparam int VALUE_W  = 53;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  // shared multiplier: signed 50 x signed 21
  localparam int MUL_A_W = OFFSET_W + 2;
  localparam int MUL_B_W = SLOPE_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [MUL_P_W-1:0] mul_p_t;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

FILE: hw/rtl/lemq_ram.sv
// generic single write, single read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module lemq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/lemq_mul.sv
// shared signed multiplier with registered product
// depends on lemq_pkg
`timescale 1ns / 1ps

module lemq_mul (
  input  logic            clk,
  input  lemq_pkg::mul_a_t a,
  input  lemq_pkg::mul_b_t b,
  output lemq_pkg::mul_p_t p
);
  import lemq_pkg::*;

  mul_p_t p_r;

  // one product per cycle, result valid the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

FILE: hw/rtl/line_envelope_max_query.sv
// top level of the line envelope max query block: sequencer and state
// depends on lemq_pkg, lemq_ram, lemq_mul
`timescale 1ns / 1ps

// Keeps the upper envelope of lines y = slope*x + offset in two line RAMs.
// Input channel (in_valid / in_stall) takes one request: clear, add a line
// (slopes nondecreasing) or query the maximum at in_query_x. Each request
// gives exactly one result on the out_ channel (out_valid / out_stall) with
// the value, a status and the line count after the request.
// While a request is in work in_stall is high; one request at a time.
// Clear, an unused selector and an empty query go straight to the result.
// An add checks the top line for slope order and an equal slope, then checks
// each line below the new one, popping it while it is hidden, and writes the
// new line unless the envelope is full; lines come from the registered-read
// RAMs and both cross products go through one shared multiplier. A query
// makes up to ceil(log2) of the line count binary search steps on the same
// multiplier. Each line is popped at most once.
// A finished result waits in the output register while out_stall is high;
// the sequencer holds in its last state until the register is free.
// Reset (synchronous, rst_n low) empties the envelope at once; the RAM
// contents are not cleared, read data from entries at or above the count is never used.
module line_envelope_max_query #(
  parameter int HULL_DEPTH = lemq_pkg::DEFAULT_HULL_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lemq_pkg::FUNC_W-1:0]         in_func,
  input  logic [lemq_pkg::SLOPE_W-1:0]        in_line_slope,
  input  logic [lemq_pkg::OFFSET_W-1:0]       in_line_offset,
  input  logic signed [lemq_pkg::X_W-1:0]     in_query_x,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lemq_pkg::VALUE_W-1:0] out_max_value,
  output logic [lemq_pkg::STATUS_W-1:0]       out_status,
  output logic [lemq_pkg::COUNT_W-1:0]        out_line_count
);
  import lemq_pkg::*;

  localparam int AW = $clog2(HULL_DEPTH);
  localparam int CW = $clog2(HULL_DEPTH + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHK_TOP   = 4'd1;
  localparam logic [3:0] S_POP_CHK   = 4'd2;
  localparam logic [3:0] S_POP_RD2   = 4'd3;
  localparam logic [3:0] S_POP_M1    = 4'd4;
  localparam logic [3:0] S_POP_M2    = 4'd5;
  localparam logic [3:0] S_POP_CMP   = 4'd6;
  localparam logic [3:0] S_ADD_END   = 4'd7;
  localparam logic [3:0] S_Q_LOOP    = 4'd8;
  localparam logic [3:0] S_Q_RD2     = 4'd9;
  localparam logic [3:0] S_Q_MUL     = 4'd10;
  localparam logic [3:0] S_Q_CMP     = 4'd11;
  localparam logic [3:0] S_Q_FIN_MUL = 4'd12;
  localparam logic [3:0] S_Q_FIN_ADD = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  // control registers
  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] top_r, top_nxt;
  logic [CW-1:0] t_r, t_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] mid_r, mid_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic [FUNC_W-1:0]         func_r, func_nxt;
  logic [SLOPE_W-1:0]        s_r, s_nxt;
  logic [OFFSET_W-1:0]       c_r, c_nxt;
  logic signed [X_W-1:0]     x_r, x_nxt;
  logic [SLOPE_W-1:0]        ts_r, ts_nxt;
  logic [OFFSET_W-1:0]       tc_r, tc_nxt;
  logic [SLOPE_W-1:0]        us_r, us_nxt;
  logic [OFFSET_W-1:0]       uc_r, uc_nxt;
  mul_p_t                    lhs_r, lhs_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic signed [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;

  // ram and multiplier hookup
  logic                rd_unused;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [SLOPE_W-1:0]  rd_slope;
  logic [OFFSET_W-1:0] rd_offset;
  mul_a_t              mul_a;
  mul_b_t              mul_b;
  mul_p_t              mul_p;

  logic [CW-1:0]       span;
  logic [CW-1:0]       mid_wide;
  logic [CW+COUNT_W-1:0] top_ext;

  assign rd_unused = 1'b0;

  lemq_ram #(.WIDTH(SLOPE_W), .DEPTH(HULL_DEPTH)) u_slope_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (t_r[AW-1:0]),
    .wr_data (s_r),
    .rd_addr (rd_addr),
    .rd_data (rd_slope)
  );

  lemq_ram #(.WIDTH(OFFSET_W), .DEPTH(HULL_DEPTH)) u_offset_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (t_r[AW-1:0]),
    .wr_data (c_r),
    .rd_addr (rd_addr),
    .rd_data (rd_offset)
  );

  lemq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // binary search midpoint, rounded up
  assign span     = CW'(hi_r) - CW'(lo_r) + CW'(1);
  assign mid_wide = CW'(lo_r) + (span >> 1);
  assign top_ext  = {{COUNT_W{1'b0}}, top_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    t_nxt          = t_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    out_valid_nxt  = out_valid_r;
    func_nxt       = func_r;
    s_nxt          = s_r;
    c_nxt          = c_r;
    x_nxt          = x_r;
    ts_nxt         = ts_r;
    tc_nxt         = tc_r;
    us_nxt         = us_r;
    uc_nxt         = uc_r;
    lhs_nxt        = lhs_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    rd_addr        = '0;
    wr_en          = rd_unused;
    mul_a          = '0;
    mul_b          = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_addr = AW'(top_r - CW'(1));
        if (in_valid) begin
          func_nxt       = in_func;
          s_nxt          = in_line_slope;
          c_nxt          = in_line_offset;
          x_nxt          = in_query_x;
          res_status_nxt = ST_OK;
          res_value_nxt  = '0;
          t_nxt          = top_r;
          lo_nxt         = '0;
          hi_nxt         = AW'(top_r - CW'(1));
          case (in_func)
            FUNC_CLEAR: begin
              top_nxt   = '0;
              state_nxt = S_DONE;
            end
            FUNC_ADD: begin
              state_nxt = (top_r == '0) ? S_POP_CHK : S_CHK_TOP;
            end
            FUNC_QUERY: begin
              if (top_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_Q_LOOP;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // top line against the new slope
      S_CHK_TOP: begin
        if (s_r < rd_slope) begin
          res_status_nxt = ST_ORDER;
          state_nxt      = S_DONE;
        end else if (s_r == rd_slope && rd_offset >= c_r) begin
          state_nxt = S_DONE;
        end else begin
          if (s_r == rd_slope) begin
            t_nxt = t_r - CW'(1);
          end
          state_nxt = S_POP_CHK;
        end
      end

      S_POP_CHK: begin
        rd_addr = AW'(t_r - CW'(1));
        if (t_r > CW'(1)) begin
          state_nxt = S_POP_RD2;
        end else begin
          state_nxt = S_ADD_END;
        end
      end

      S_POP_RD2: begin
        ts_nxt    = rd_slope;
        tc_nxt    = rd_offset;
        rd_addr   = AW'(t_r - CW'(2));
        state_nxt = S_POP_M1;
      end

      // left cross product (tc - c) * (ts - us)
      S_POP_M1: begin
        us_nxt    = rd_slope;
        uc_nxt    = rd_offset;
        mul_a     = mul_a_t'({2'b00, tc_r}) - mul_a_t'({2'b00, c_r});
        mul_b     = mul_b_t'({1'b0, ts_r}) - mul_b_t'({1'b0, rd_slope});
        state_nxt = S_POP_M2;
      end

      // right cross product (uc - tc) * (s - ts)
      S_POP_M2: begin
        lhs_nxt   = mul_p;
        mul_a     = mul_a_t'({2'b00, uc_r}) - mul_a_t'({2'b00, tc_r});
        mul_b     = mul_b_t'({1'b0, s_r}) - mul_b_t'({1'b0, ts_r});
        state_nxt = S_POP_CMP;
      end

      S_POP_CMP: begin
        if (lhs_r <= mul_p) begin
          t_nxt     = t_r - CW'(1);
          state_nxt = S_POP_CHK;
        end else begin
          state_nxt = S_ADD_END;
        end
      end

      S_ADD_END: begin
        if (t_r >= CW'(HULL_DEPTH)) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          top_nxt = t_r + CW'(1);
        end
        state_nxt = S_DONE;
      end

      // search step: read lines mid-1 and mid
      S_Q_LOOP: begin
        if (lo_r < hi_r) begin
          mid_nxt   = AW'(mid_wide);
          rd_addr   = AW'(mid_wide - CW'(1));
          state_nxt = S_Q_RD2;
        end else begin
          rd_addr   = lo_r;
          state_nxt = S_Q_FIN_MUL;
        end
      end

      S_Q_RD2: begin
        ts_nxt    = rd_slope;
        tc_nxt    = rd_offset;
        rd_addr   = mid_r;
        state_nxt = S_Q_MUL;
      end

      // x * slope difference against offset difference
      S_Q_MUL: begin
        lhs_nxt   = mul_p_t'(mul_a_t'({2'b00, tc_r}) - mul_a_t'({2'b00, rd_offset}));
        mul_a     = mul_a_t'(x_r);
        mul_b     = mul_b_t'({1'b0, rd_slope}) - mul_b_t'({1'b0, ts_r});
        state_nxt = S_Q_CMP;
      end

      S_Q_CMP: begin
        if (lhs_r < mul_p) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r - AW'(1);
        end
        state_nxt = S_Q_LOOP;
      end

      S_Q_FIN_MUL: begin
        tc_nxt    = rd_offset;
        mul_a     = mul_a_t'(x_r);
        mul_b     = mul_b_t'({1'b0, rd_slope});
        state_nxt = S_Q_FIN_ADD;
      end

      S_Q_FIN_ADD: begin
        res_value_nxt = VALUE_W'(mul_p + mul_p_t'({2'b00, tc_r}));
        state_nxt     = S_DONE;
      end

      // hand the result to the output register when it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = top_ext[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      t_r         <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      mid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      t_r         <= t_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    s_r          <= s_nxt;
    c_r          <= c_nxt;
    x_r          <= x_nxt;
    ts_r         <= ts_nxt;
    tc_r         <= tc_nxt;
    us_r         <= us_nxt;
    uc_r         <= uc_nxt;
    lhs_r        <= lhs_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_max_value  = out_value_r;
  assign out_status     = out_status_r;
  assign out_line_count = out_count_r;

  // checks
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CW'(HULL_DEPTH))
    else $error("line count above depth");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  a_pop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_CHK) |-> (t_r <= top_r))
    else $error("pop index above line count");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_RD2) |-> (mid_r > lo_r && mid_r <= hi_r))
    else $error("search midpoint out of range");

  a_func_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DONE) |=> $stable(func_r))
    else $error("request changed during work");

endmodule

FILE: tb/line_envelope_max_query_tb.sv
// testbench for line_envelope_max_query: directed, full-stack and random request tests
// checks every result against an internal envelope predictor; depends on lemq_pkg and the rtl
`timescale 1ns / 1ps

module line_envelope_max_query_tb;
  import lemq_pkg::*;

  localparam int DEPTH = DEFAULT_HULL_DEPTH;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] line_count;
  } envelope_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [SLOPE_W-1:0] in_line_slope;
  logic [OFFSET_W-1:0] in_line_offset;
  logic signed [X_W-1:0] in_query_x;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_max_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_line_count;

  // predictor copy of the envelope
  logic [SLOPE_W-1:0] env_slope [DEPTH];
  logic [OFFSET_W-1:0] env_offset [DEPTH];
  int unsigned env_count;

  envelope_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit quiet_mode;
  int unsigned stall_left = 0;

  line_envelope_max_query i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_line_slope(in_line_slope),
    .in_line_offset(in_line_offset), .in_query_x(in_query_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_max_value(out_max_value), .out_status(out_status),
    .out_line_count(out_line_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // middle line is dropped when the new line meets the lower one no later
  function automatic bit middle_is_hidden(int unsigned t, logic [SLOPE_W-1:0] s,
                                          logic [OFFSET_W-1:0] c);
    logic signed [127:0] top_c, low_c, new_c, top_s, low_s, new_s, lhs, rhs;
    top_c = env_offset[t-1];
    low_c = env_offset[t-2];
    new_c = c;
    top_s = env_slope[t-1];
    low_s = env_slope[t-2];
    new_s = s;
    lhs = (top_c - new_c) * (top_s - low_s);
    rhs = (low_c - top_c) * (new_s - top_s);
    return lhs <= rhs;
  endfunction

  task automatic predict_request(input logic [FUNC_W-1:0] f, input logic [SLOPE_W-1:0] s,
                                 input logic [OFFSET_W-1:0] c, input logic signed [X_W-1:0] x);
    envelope_result_t r;
    int unsigned t, lo, hi, mid;
    longint diff_c, diff_x, v;
    r = '0;
    case (f)
      FUNC_CLEAR: env_count = 0;
      FUNC_ADD: begin
        t = env_count;
        if (t > 0 && s < env_slope[t-1]) begin
          r.status = ST_ORDER;
        end else if (!(t > 0 && s == env_slope[t-1] && env_offset[t-1] >= c)) begin
          if (t > 0 && s == env_slope[t-1]) t--;
          while (t > 1 && middle_is_hidden(t, s, c)) t--;
          if (t >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            env_slope[t] = s;
            env_offset[t] = c;
            env_count = t + 1;
          end
        end
      end
      FUNC_QUERY: begin
        if (env_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = 0;
          hi = env_count - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            diff_c = longint'(env_offset[mid-1]) - longint'(env_offset[mid]);
            diff_x = longint'(x) * (longint'(env_slope[mid]) - longint'(env_slope[mid-1]));
            if (diff_c < diff_x) lo = mid;
            else hi = mid - 1;
          end
          v = longint'(x) * longint'(env_slope[lo]) + longint'(env_offset[lo]);
          r.max_value = v[VALUE_W-1:0];
        end
      end
      default: ;
    endcase
    r.line_count = env_count[COUNT_W-1:0];
    pending_results.insert(pending_results.size(), r);
  endtask

  // send one request and wait for it to be taken; outside quiet mode, sometimes a random gap afterwards
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SLOPE_W-1:0] s,
                              input logic [OFFSET_W-1:0] c, input logic signed [X_W-1:0] x);
    in_valid <= 1'b1;
    in_func <= f;
    in_line_slope <= s;
    in_line_offset <= c;
    in_query_x <= x;
    do @(posedge clk); while (in_stall);
    predict_request(f, s, c, x);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off until every expected result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] random_offset();
    return OFFSET_W'({$urandom, $urandom});
  endfunction

  // result check and receiver stall bursts
  always @(posedge clk) begin
    envelope_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_max_value !== exp_r.max_value) begin
          $error("max_value expected %0d actual %0d", exp_r.max_value, out_max_value);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_line_count !== exp_r.line_count) begin
          $error("line_count expected %0d actual %0d", exp_r.line_count, out_line_count);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL line_envelope_max_query");
      $finish;
    end
  end

  // empty envelope, unused selector and clear
  task automatic test_empty_envelope();
    send_request(FUNC_QUERY, '0, '0, 32'sd0);
    send_request(FUNC_UNUSED, '1, '1, -32'sd1);
    send_request(FUNC_CLEAR, '0, '0, 32'sd0);
    send_request(FUNC_QUERY, '1, '1, 32'sh7fffffff);
  endtask

  // field extremes, equal slopes, order reject and breakpoint tie
  task automatic test_directed_lines();
    send_request(FUNC_ADD, '0, '1, 32'sd0);
    send_request(FUNC_ADD, '0, '0, 32'sd0);
    send_request(FUNC_ADD, '0, '1, 32'sd0);
    send_request(FUNC_QUERY, '0, '0, 32'sh80000000);
    send_request(FUNC_ADD, 20'd5, 48'd0, 32'sd0);
    send_request(FUNC_ADD, 20'd3, 48'd7, 32'sd0);
    send_request(FUNC_ADD, '1, '0, 32'sd0);
    send_request(FUNC_QUERY, '0, '0, 32'sh7fffffff);
    send_request(FUNC_QUERY, '0, '0, 32'sh80000000);
    send_request(FUNC_QUERY, '0, '0, 32'sd0);
    send_request(FUNC_CLEAR, '0, '0, 32'sd0);
    send_request(FUNC_ADD, 20'd0, 48'd10, 32'sd0);
    send_request(FUNC_ADD, 20'd2, 48'd0, 32'sd0);
    send_request(FUNC_QUERY, '0, '0, 32'sd5);
    send_request(FUNC_QUERY, '0, '0, 32'sd4);
    send_request(FUNC_QUERY, '0, '0, 32'sd6);
    // equal slope with a larger offset replaces the top
    send_request(FUNC_ADD, 20'd2, 48'd3, 32'sd0);
    send_request(FUNC_ADD, 20'd1, 48'd8, 32'sd0);
    send_request(FUNC_QUERY, '0, '0, -32'sd3);
    send_request(FUNC_CLEAR, '0, '0, 32'sd0);
  endtask

  // fill the stack with lines that all stay, then overflow it
  task automatic test_full_stack();
    longint base;
    base = longint'(1) << 40;
    send_request(FUNC_CLEAR, '0, '0, 32'sd0);
    for (int k = 0; k < DEPTH; k++) begin
      send_request(FUNC_ADD, SLOPE_W'(k), OFFSET_W'(base - longint'(k) * k), 32'sd0);
    end
    send_request(FUNC_ADD, SLOPE_W'(DEPTH), OFFSET_W'(base - longint'(DEPTH) * DEPTH), 32'sd0);
    send_request(FUNC_QUERY, '0, '0, 32'sd1000);
    send_request(FUNC_QUERY, '0, '0, -32'sd5);
    send_request(FUNC_ADD, SLOPE_W'(DEPTH + 5), OFFSET_W'(base * 4), 32'sd0);
    send_request(FUNC_QUERY, '0, '0, 32'sd7);
    wait_results_drained();
  endtask

  // random well-formed sequences with some noise
  task automatic test_random_requests(input int unsigned num_items);
    int unsigned sent, pick;
    logic [SLOPE_W-1:0] s, top_s;
    logic [OFFSET_W-1:0] c;
    logic signed [X_W-1:0] x;
    sent = 0;
    while (sent < num_items) begin
      if (sent + 300 >= num_items) quiet_mode = 1'b1;
      if ($urandom_range(0, 24) == 0) begin
        send_request(FUNC_CLEAR, SLOPE_W'($urandom), random_offset(), X_W'($urandom));
        sent++;
        continue;
      end
      top_s = (env_count > 0) ? env_slope[env_count-1] : SLOPE_W'(0);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) c = random_offset();
      else c = OFFSET_W'($urandom_range(0, 5000));
      if ($urandom_range(0, 1)) x = X_W'($urandom);
      else x = X_W'($urandom_range(0, 4000)) - 32'sd2000;
      if (pick < 55) begin
        case ($urandom_range(0, 3))
          0: s = top_s + SLOPE_W'($urandom_range(0, 3));
          1: s = top_s + SLOPE_W'($urandom_range(0, 2000));
          2: s = (env_count == 0) ? SLOPE_W'($urandom) : top_s + SLOPE_W'($urandom_range(0, 60));
          default: s = top_s;
        endcase
        if (s < top_s) s = top_s;
        send_request(FUNC_ADD, s, c, x);
      end else if (pick < 88) begin
        send_request(FUNC_QUERY, SLOPE_W'($urandom), c, x);
      end else if (pick < 93) begin
        send_request(FUNC_UNUSED, SLOPE_W'($urandom), c, x);
      end else begin
        send_request(FUNC_ADD, SLOPE_W'($urandom), c, x);
      end
      sent++;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_CLEAR;
    in_line_slope <= '0;
    in_line_offset <= '0;
    in_query_x <= '0;
    env_count = 0;
    quiet_mode = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_envelope();
    test_directed_lines();
    wait_results_drained();
    test_full_stack();
    test_random_requests(950);
    wait_results_drained();
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS line_envelope_max_query");
    end else begin
      $display("FAIL line_envelope_max_query");
    end
    $finish;
  end

endmodule
